// ===== rtl/etxlq_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, types and helper functions of the link quality estimator
// no dependencies
package etxlq_pkg;

   // window geometry
   localparam int WINDOW_SLOTS     = 32;
   localparam int QUICKSTART_SLOTS = 4;
   localparam int SLOT_W           = $clog2(WINDOW_SLOTS);
   localparam int WLEN_W           = $clog2(WINDOW_SLOTS + 1);

   // counters
   localparam int              CNT_W     = 16;
   localparam logic [CNT_W-1:0] CNT_MAX   = '1;
   localparam logic [CNT_W-1:0] LOST_INIT = 16'd3;
   localparam logic [CNT_W-1:0] GAP_LIMIT = 16'd256;

   // field widths
   localparam int SEQ_W   = 16;
   localparam int LQ_W    = 8;
   localparam int COST_W  = 32;
   localparam int MULT_W  = 17;
   localparam int HELLO_W = 8;
   localparam int CMD_W   = 2;

   localparam logic [MULT_W-1:0] MULT_ONE = 17'd65536;
   localparam logic [LQ_W-1:0]   LQ_MAX   = 8'd255;

   // 65536 * 255, numerator of the first cost division
   localparam int                   COST_NUM_W = 24;
   localparam logic [COST_NUM_W-1:0] COST_NUM  = 24'd16711680;

   // serial arithmetic unit
   localparam int NUM_W  = 33;
   localparam int DEN_W  = 17;
   localparam int STEP_W = $clog2(NUM_W + 1);

   localparam logic [STEP_W-1:0] STEPS_IDLE_DIV = STEP_W'(CNT_W);
   localparam logic [STEP_W-1:0] STEPS_MUL      = STEP_W'(CNT_W);
   localparam logic [STEP_W-1:0] STEPS_LQ_DIV   = STEP_W'(NUM_W);
   localparam logic [STEP_W-1:0] STEPS_C1_DIV   = STEP_W'(COST_NUM_W);
   localparam logic [STEP_W-1:0] STEPS_C2_DIV   = STEP_W'(COST_W);

   // commands
   localparam logic [CMD_W-1:0] CMD_PACKET   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TICK     = 2'd1;
   localparam logic [CMD_W-1:0] CMD_NEIGHBOR = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd3;

   // control registers
   localparam int               CSR_IDX_W  = 2;
   localparam int               CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_LOSS_MULT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HELLO      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LQ     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BROKEN     = 2'd3;

   localparam logic [HELLO_W-1:0] HELLO_RST  = 8'd2;
   localparam logic [LQ_W-1:0]    MIN_LQ_RST = 8'd25;
   localparam logic [COST_W-1:0]  BROKEN_RST = 32'd4194304;

   typedef struct packed {
      logic              rd_en;
      logic              wr_en;
      logic              clr_lost;
      logic [SLOT_W-1:0] addr;
      logic [CNT_W-1:0]  wr_recv;
      logic [CNT_W-1:0]  wr_lost;
   } win_req_type;

   typedef struct packed {
      logic [CNT_W-1:0] recv;
      logic [CNT_W-1:0] lost;
   } win_rsp_type;

   typedef struct packed {
      logic              start;
      logic              op_mul;
      logic [NUM_W-1:0]  num;
      logic [DEN_W-1:0]  den;
      logic [STEP_W-1:0] steps;
   } alu_req_type;

   typedef struct packed {
      logic             done;
      logic [NUM_W-1:0] res;
   } alu_rsp_type;

   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
      logic [CNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
   endfunction

endpackage

// ===== rtl/etx_link_quality_estimator.sv =====
`timescale 1ns / 1ps
// top level of the link quality estimator: control sequencer, control registers, result word
// depends on etxlq_pkg, etxlq_window, etxlq_serial_alu
//
// usage
// - req channel (valid/ready) takes one word per event: packet received (seq_no),
//   one-second tick, neighbor quality update (neighbor_lq) or clear link
// - rsp channel (valid/ready) returns one word per request word: lq, nlq, etx cost
//   and the duplicate flag of a packet word
// - csr port writes loss multiplier, hello period, minimum quality and broken cost;
//   write only while no request word is in flight
// - one word at a time; req_ready is high only when the sequencer is idle
// - the work on each word is set by the bit-serial divide/multiply unit: the cost
//   update runs two serial divisions, skipped when the link is broken; a new packet
//   word also does a read-modify-write of its slot, a repeated one does not;
//   rsp_valid rises in the same cycle as req_ready
// - a tick adds the slot sweep and advance (one memory read per cycle) and four
//   serial ops of 16, 16, 16 and 33 steps, all skipped when the window sums hold
//   no received and no lost counts
// - a finished word sits in the rsp register; a new request is accepted while it
//   waits, and the sequencer holds the next result until rsp_ready frees the register
// - synchronous reset: registers to defaults, window counts read as received 0 /
//   lost 3 through valid bits, quick start window, no result pending
module etx_link_quality_estimator (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [etxlq_pkg::CMD_W-1:0]        req_cmd,
   input  logic [etxlq_pkg::SEQ_W-1:0]        req_seq_no,
   input  logic [etxlq_pkg::LQ_W-1:0]         req_neighbor_lq,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [etxlq_pkg::LQ_W-1:0]         rsp_lq_out,
   output logic [etxlq_pkg::LQ_W-1:0]         rsp_nlq_out,
   output logic [etxlq_pkg::COST_W-1:0]       rsp_cost_out,
   output logic                               rsp_dup_seen,
   // control registers
   input  logic                               csr_wr_en,
   input  logic [etxlq_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [etxlq_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_PKT   = 4'd1;   // read-modify-write of current slot
   localparam logic [3:0] S_SUM   = 4'd2;   // sweep of window slots
   localparam logic [3:0] S_MDIV  = 4'd3;   // missed hellos = idle / period
   localparam logic [3:0] S_SQMUL = 4'd4;   // missed hellos squared
   localparam logic [3:0] S_RMUL  = 4'd5;   // multiplier * received
   localparam logic [3:0] S_RDIV  = 4'd6;   // ... / (received + lost)
   localparam logic [3:0] S_ADV   = 4'd7;   // advance and clear slot
   localparam logic [3:0] S_COST  = 4'd8;   // broken check, start cost division
   localparam logic [3:0] S_C1DIV = 4'd9;
   localparam logic [3:0] S_C2DIV = 4'd10;
   localparam logic [3:0] S_OUT   = 4'd11;  // hand result to rsp register

   logic [3:0] state_ff, state_in;

   // control registers
   logic [etxlq_pkg::MULT_W-1:0]  mult_ff, mult_in;
   logic [etxlq_pkg::HELLO_W-1:0] hello_ff, hello_in;
   logic [etxlq_pkg::LQ_W-1:0]    minlq_ff, minlq_in;
   logic [etxlq_pkg::COST_W-1:0]  broken_ff, broken_in;

   // link state
   logic [etxlq_pkg::SEQ_W-1:0]   last_seq_ff, last_seq_in;
   logic [etxlq_pkg::SLOT_W-1:0]  slot_ff, slot_in;
   logic [etxlq_pkg::WLEN_W-1:0]  wlen_ff, wlen_in;
   logic [etxlq_pkg::CNT_W-1:0]   idle_ff, idle_in;
   logic [etxlq_pkg::LQ_W-1:0]    lq_ff, lq_in;
   logic [etxlq_pkg::LQ_W-1:0]    nlq_ff, nlq_in;

   // per-word working registers
   logic [etxlq_pkg::SEQ_W-1:0]   seq_ff, seq_in;
   logic                          dup_ff, dup_in;
   logic [etxlq_pkg::WLEN_W-1:0]  idx_ff, idx_in;
   logic                          acc_vld_ff, acc_vld_in;
   logic [etxlq_pkg::CNT_W-1:0]   rec_sum_ff, rec_sum_in;
   logic [etxlq_pkg::CNT_W-1:0]   lost_sum_ff, lost_sum_in;
   logic [etxlq_pkg::COST_W-1:0]  cost_ff, cost_in;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [etxlq_pkg::LQ_W-1:0]    rsp_lq_ff, rsp_lq_in;
   logic [etxlq_pkg::LQ_W-1:0]    rsp_nlq_ff, rsp_nlq_in;
   logic [etxlq_pkg::COST_W-1:0]  rsp_cost_ff, rsp_cost_in;
   logic                          rsp_dup_ff, rsp_dup_in;

   etxlq_pkg::win_req_type win_req;
   etxlq_pkg::win_rsp_type win_rsp;
   etxlq_pkg::alu_req_type alu_req;
   etxlq_pkg::alu_rsp_type alu_rsp;

   // derived values
   logic                          req_fire;
   logic [etxlq_pkg::HELLO_W-1:0] hello_eff;
   logic [etxlq_pkg::MULT_W-1:0]  mult_eff;
   logic [etxlq_pkg::COST_W-1:0]  broken_eff;
   logic                          link_broken;
   logic [etxlq_pkg::SEQ_W-1:0]   gap;
   logic [etxlq_pkg::CNT_W-1:0]   gap_lost;
   logic [etxlq_pkg::SLOT_W-1:0]  slot_next;
   logic [etxlq_pkg::MULT_W+7:0]  lq_scaled;
   logic [etxlq_pkg::COST_W-1:0]  c1_scaled;
   logic [etxlq_pkg::COST_W-1:0]  cost_raw;

   etxlq_window u_window (
      .clock   (clock),
      .reset   (reset),
      .win_req (win_req),
      .win_rsp (win_rsp)
   );

   etxlq_serial_alu u_alu (
      .clock   (clock),
      .reset   (reset),
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;

   // out-of-range register values
   assign hello_eff  = (hello_ff == '0) ? etxlq_pkg::HELLO_W'(1) : hello_ff;
   assign mult_eff   = (mult_ff > etxlq_pkg::MULT_ONE) ? etxlq_pkg::MULT_ONE : mult_ff;
   assign broken_eff = (broken_ff == '0) ? etxlq_pkg::COST_W'(1) : broken_ff;

   assign link_broken = (lq_ff < minlq_ff) || (nlq_ff < minlq_ff) ||
                        (lq_ff == '0) || (nlq_ff == '0);

   // sequence gap, wrapping; a jump beyond the limit counts as no loss
   assign gap      = seq_ff - last_seq_ff;
   assign gap_lost = (gap > etxlq_pkg::GAP_LIMIT) ? '0 : (gap - 1'b1);

   assign slot_next = (slot_ff == etxlq_pkg::SLOT_W'(etxlq_pkg::WINDOW_SLOTS - 1)) ?
                      '0 : (slot_ff + 1'b1);

   // ratio * 255 as shift and subtract; ratio never exceeds 65536
   assign lq_scaled = {alu_rsp.res[etxlq_pkg::MULT_W-1:0], 8'd0} -
                      {8'd0, alu_rsp.res[etxlq_pkg::MULT_W-1:0]};
   assign c1_scaled = {alu_rsp.res[etxlq_pkg::COST_NUM_W-1:0], 8'd0} -
                      {8'd0, alu_rsp.res[etxlq_pkg::COST_NUM_W-1:0]};
   assign cost_raw  = alu_rsp.res[etxlq_pkg::COST_W-1:0];

   always_comb begin
      state_in     = state_ff;
      mult_in      = mult_ff;
      hello_in     = hello_ff;
      minlq_in     = minlq_ff;
      broken_in    = broken_ff;
      last_seq_in  = last_seq_ff;
      slot_in      = slot_ff;
      wlen_in      = wlen_ff;
      idle_in      = idle_ff;
      lq_in        = lq_ff;
      nlq_in       = nlq_ff;
      seq_in       = seq_ff;
      dup_in       = dup_ff;
      idx_in       = idx_ff;
      acc_vld_in   = acc_vld_ff;
      rec_sum_in   = rec_sum_ff;
      lost_sum_in  = lost_sum_ff;
      cost_in      = cost_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_lq_in    = rsp_lq_ff;
      rsp_nlq_in   = rsp_nlq_ff;
      rsp_cost_in  = rsp_cost_ff;
      rsp_dup_in   = rsp_dup_ff;
      win_req      = '0;
      alu_req      = '0;

      // register writes must arrive only while idle; the block itself does not enforce this
      if (csr_wr_en) begin
         unique case (csr_index)
            etxlq_pkg::CSR_LOSS_MULT: mult_in   = csr_wdata[etxlq_pkg::MULT_W-1:0];
            etxlq_pkg::CSR_HELLO:     hello_in  = csr_wdata[etxlq_pkg::HELLO_W-1:0];
            etxlq_pkg::CSR_MIN_LQ:    minlq_in  = csr_wdata[etxlq_pkg::LQ_W-1:0];
            etxlq_pkg::CSR_BROKEN:    broken_in = csr_wdata[etxlq_pkg::COST_W-1:0];
            default:                  ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               seq_in = req_seq_no;
               dup_in = 1'b0;
               unique case (req_cmd)
                  etxlq_pkg::CMD_PACKET: begin
                     if (req_seq_no == last_seq_ff) begin
                        dup_in   = 1'b1;
                        state_in = S_COST;
                     end else begin
                        win_req.rd_en = 1'b1;
                        win_req.addr  = slot_ff;
                        state_in      = S_PKT;
                     end
                  end
                  etxlq_pkg::CMD_TICK: begin
                     // quick start: window grows one slot per tick
                     if (wlen_ff < etxlq_pkg::WLEN_W'(etxlq_pkg::WINDOW_SLOTS)) begin
                        wlen_in = wlen_ff + 1'b1;
                     end
                     idx_in      = '0;
                     acc_vld_in  = 1'b0;
                     rec_sum_in  = '0;
                     lost_sum_in = '0;
                     state_in    = S_SUM;
                  end
                  etxlq_pkg::CMD_NEIGHBOR: begin
                     nlq_in   = req_neighbor_lq;
                     state_in = S_COST;
                  end
                  etxlq_pkg::CMD_CLEAR: begin
                     wlen_in          = etxlq_pkg::WLEN_W'(etxlq_pkg::QUICKSTART_SLOTS);
                     win_req.clr_lost = 1'b1;
                     state_in         = S_COST;
                  end
                  default: ;
               endcase
            end
         end

         S_PKT: begin
            win_req.wr_en   = 1'b1;
            win_req.addr    = slot_ff;
            win_req.wr_recv = etxlq_pkg::sat_add(win_rsp.recv, etxlq_pkg::CNT_W'(1));
            win_req.wr_lost = etxlq_pkg::sat_add(win_rsp.lost, gap_lost);
            last_seq_in     = seq_ff;
            idle_in         = '0;
            state_in        = S_COST;
         end

         S_SUM: begin
            // read one slot per cycle, accumulate it in the next cycle
            if (acc_vld_ff) begin
               rec_sum_in  = etxlq_pkg::sat_add(rec_sum_ff, win_rsp.recv);
               lost_sum_in = etxlq_pkg::sat_add(lost_sum_ff, win_rsp.lost);
            end
            if (idx_ff < wlen_ff) begin
               win_req.rd_en = 1'b1;
               win_req.addr  = idx_ff[etxlq_pkg::SLOT_W-1:0];
               idx_in        = idx_ff + 1'b1;
               acc_vld_in    = 1'b1;
            end else begin
               acc_vld_in = 1'b0;
               if (!acc_vld_ff) begin
                  if (rec_sum_ff == '0 && lost_sum_ff == '0) begin
                     lq_in    = '0;
                     state_in = S_ADV;
                  end else begin
                     alu_req.start  = 1'b1;
                     alu_req.op_mul = 1'b0;
                     alu_req.num    = {idle_ff, (etxlq_pkg::NUM_W - etxlq_pkg::CNT_W)'(0)};
                     alu_req.den    = {(etxlq_pkg::DEN_W - etxlq_pkg::HELLO_W)'(0), hello_eff};
                     alu_req.steps  = etxlq_pkg::STEPS_IDLE_DIV;
                     state_in       = S_MDIV;
                  end
               end
            end
         end

         S_MDIV: begin
            if (alu_rsp.done) begin
               alu_req.start  = 1'b1;
               alu_req.op_mul = 1'b1;
               alu_req.num    = {(etxlq_pkg::NUM_W - etxlq_pkg::CNT_W)'(0),
                                 alu_rsp.res[etxlq_pkg::CNT_W-1:0]};
               alu_req.den    = {(etxlq_pkg::DEN_W - etxlq_pkg::CNT_W)'(0),
                                 alu_rsp.res[etxlq_pkg::CNT_W-1:0]};
               alu_req.steps  = etxlq_pkg::STEPS_MUL;
               state_in       = S_SQMUL;
            end
         end

         S_SQMUL: begin
            if (alu_rsp.done) begin
               // missed hello penalty joins the lost sum, saturating
               if (alu_rsp.res >= {(etxlq_pkg::NUM_W - etxlq_pkg::CNT_W)'(0),
                                   etxlq_pkg::CNT_MAX}) begin
                  lost_sum_in = etxlq_pkg::CNT_MAX;
               end else begin
                  lost_sum_in = etxlq_pkg::sat_add(lost_sum_ff,
                                                   alu_rsp.res[etxlq_pkg::CNT_W-1:0]);
               end
               alu_req.start  = 1'b1;
               alu_req.op_mul = 1'b1;
               alu_req.num    = {(etxlq_pkg::NUM_W - etxlq_pkg::CNT_W)'(0), rec_sum_ff};
               alu_req.den    = mult_eff;
               alu_req.steps  = etxlq_pkg::STEPS_MUL;
               state_in       = S_RMUL;
            end
         end

         S_RMUL: begin
            if (alu_rsp.done) begin
               alu_req.start  = 1'b1;
               alu_req.op_mul = 1'b0;
               alu_req.num    = alu_rsp.res;
               alu_req.den    = {1'b0, rec_sum_ff} + {1'b0, lost_sum_ff};
               alu_req.steps  = etxlq_pkg::STEPS_LQ_DIV;
               state_in       = S_RDIV;
            end
         end

         S_RDIV: begin
            if (alu_rsp.done) begin
               if (lq_scaled[etxlq_pkg::MULT_W+7:16] > {1'b0, etxlq_pkg::LQ_MAX}) begin
                  lq_in = etxlq_pkg::LQ_MAX;
               end else begin
                  lq_in = lq_scaled[23:16];
               end
               state_in = S_ADV;
            end
         end

         S_ADV: begin
            slot_in         = slot_next;
            win_req.wr_en   = 1'b1;
            win_req.addr    = slot_next;
            win_req.wr_recv = '0;
            win_req.wr_lost = '0;
            idle_in         = etxlq_pkg::sat_add(idle_ff, etxlq_pkg::CNT_W'(1));
            state_in        = S_COST;
         end

         S_COST: begin
            if (link_broken) begin
               cost_in  = broken_eff;
               state_in = S_OUT;
            end else begin
               // 65536*255 / lq
               alu_req.start  = 1'b1;
               alu_req.op_mul = 1'b0;
               alu_req.num    = {etxlq_pkg::COST_NUM,
                                 (etxlq_pkg::NUM_W - etxlq_pkg::COST_NUM_W)'(0)};
               alu_req.den    = {(etxlq_pkg::DEN_W - etxlq_pkg::LQ_W)'(0), lq_ff};
               alu_req.steps  = etxlq_pkg::STEPS_C1_DIV;
               state_in       = S_C1DIV;
            end
         end

         S_C1DIV: begin
            if (alu_rsp.done) begin
               // (... * 255) / nlq
               alu_req.start  = 1'b1;
               alu_req.op_mul = 1'b0;
               alu_req.num    = {c1_scaled, (etxlq_pkg::NUM_W - etxlq_pkg::COST_W)'(0)};
               alu_req.den    = {(etxlq_pkg::DEN_W - etxlq_pkg::LQ_W)'(0), nlq_ff};
               alu_req.steps  = etxlq_pkg::STEPS_C2_DIV;
               state_in       = S_C2DIV;
            end
         end

         S_C2DIV: begin
            if (alu_rsp.done) begin
               if (cost_raw > broken_eff) begin
                  cost_in = broken_eff;
               end else if (cost_raw == '0) begin
                  cost_in = etxlq_pkg::COST_W'(1);
               end else begin
                  cost_in = cost_raw;
               end
               state_in = S_OUT;
            end
         end

         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_lq_in    = lq_ff;
               rsp_nlq_in   = nlq_ff;
               rsp_cost_in  = cost_ff;
               rsp_dup_in   = dup_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mult_ff      <= etxlq_pkg::MULT_ONE;
         hello_ff     <= etxlq_pkg::HELLO_RST;
         minlq_ff     <= etxlq_pkg::MIN_LQ_RST;
         broken_ff    <= etxlq_pkg::BROKEN_RST;
         last_seq_ff  <= '0;
         slot_ff      <= '0;
         wlen_ff      <= etxlq_pkg::WLEN_W'(etxlq_pkg::QUICKSTART_SLOTS);
         idle_ff      <= '0;
         lq_ff        <= '0;
         nlq_ff       <= '0;
         idx_ff       <= '0;
         acc_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mult_ff      <= mult_in;
         hello_ff     <= hello_in;
         minlq_ff     <= minlq_in;
         broken_ff    <= broken_in;
         last_seq_ff  <= last_seq_in;
         slot_ff      <= slot_in;
         wlen_ff      <= wlen_in;
         idle_ff      <= idle_in;
         lq_ff        <= lq_in;
         nlq_ff       <= nlq_in;
         idx_ff       <= idx_in;
         acc_vld_ff   <= acc_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seq_ff      <= seq_in;
      dup_ff      <= dup_in;
      rec_sum_ff  <= rec_sum_in;
      lost_sum_ff <= lost_sum_in;
      cost_ff     <= cost_in;
      rsp_lq_ff   <= rsp_lq_in;
      rsp_nlq_ff  <= rsp_nlq_in;
      rsp_cost_ff <= rsp_cost_in;
      rsp_dup_ff  <= rsp_dup_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_lq_out   = rsp_lq_ff;
   assign rsp_nlq_out  = rsp_nlq_ff;
   assign rsp_cost_out = rsp_cost_ff;
   assign rsp_dup_seen = rsp_dup_ff;

`ifndef SYNTHESIS
   a_one_word_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous word still in progress");

   a_cost_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cost_out != '0)
      else $error("zero cost in result word");

   a_window_len_range: assert property (@(posedge clock) disable iff (reset)
      wlen_ff >= etxlq_pkg::WLEN_W'(etxlq_pkg::QUICKSTART_SLOTS) &&
      wlen_ff <= etxlq_pkg::WLEN_W'(etxlq_pkg::WINDOW_SLOTS))
      else $error("window length out of range");

   a_alu_idle_when_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !alu_rsp.done)
      else $error("serial unit finished while sequencer idle");
`endif

endmodule

// ===== rtl/etxlq_serial_alu.sv =====
`timescale 1ns / 1ps
// bit-serial arithmetic unit: restoring divide and shift-add multiply, one bit per cycle
// depends on etxlq_pkg
module etxlq_serial_alu (
   input  logic                   clock,
   input  logic                   reset,
   input  etxlq_pkg::alu_req_type alu_req,
   output etxlq_pkg::alu_rsp_type alu_rsp
);

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic                             op_mul_ff, op_mul_in;
   logic [etxlq_pkg::STEP_W-1:0]     cnt_ff, cnt_in;
   logic [etxlq_pkg::NUM_W-1:0]      quo_ff, quo_in;
   logic [etxlq_pkg::DEN_W-1:0]      rem_ff, rem_in;
   logic [etxlq_pkg::DEN_W-1:0]      den_ff, den_in;

   logic [etxlq_pkg::DEN_W:0]        shifted;
   logic [etxlq_pkg::DEN_W:0]        diff;
   logic                             ge;
   logic [etxlq_pkg::DEN_W:0]        psum;

   // divide: shift in next dividend bit, subtract when it fits
   assign shifted = {rem_ff, quo_ff[etxlq_pkg::NUM_W-1]};
   assign ge      = shifted >= {1'b0, den_ff};
   assign diff    = shifted - {1'b0, den_ff};
   // multiply: add multiplicand on multiplier lsb, shift right
   assign psum    = {1'b0, rem_ff} + (quo_ff[0] ? {1'b0, den_ff} : '0);

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      op_mul_in = op_mul_ff;
      cnt_in    = cnt_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      if (alu_req.start) begin
         busy_in   = 1'b1;
         op_mul_in = alu_req.op_mul;
         cnt_in    = alu_req.steps;
         quo_in    = alu_req.num;
         rem_in    = '0;
         den_in    = alu_req.den;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == etxlq_pkg::STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         if (op_mul_ff) begin
            rem_in = psum[etxlq_pkg::DEN_W:1];
            quo_in = {quo_ff[etxlq_pkg::NUM_W-1:etxlq_pkg::CNT_W], psum[0],
                      quo_ff[etxlq_pkg::CNT_W-1:1]};
         end else begin
            rem_in = ge ? diff[etxlq_pkg::DEN_W-1:0] : shifted[etxlq_pkg::DEN_W-1:0];
            quo_in = {quo_ff[etxlq_pkg::NUM_W-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      op_mul_ff <= op_mul_in;
      cnt_ff    <= cnt_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      den_ff    <= den_in;
   end

   assign alu_rsp.done = done_ff;
   assign alu_rsp.res  = op_mul_ff ? {rem_ff, quo_ff[etxlq_pkg::CNT_W-1:0]} : quo_ff;

`ifndef SYNTHESIS
   a_no_start_while_busy: assert property (@(posedge clock) disable iff (reset)
      alu_req.start |-> !busy_ff)
      else $error("serial alu started while busy");

   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("serial alu done while still busy");
`endif

endmodule

// ===== rtl/etxlq_window.sv =====
`timescale 1ns / 1ps
// sliding window store: received and lost counts per slot with per-entry valid bits
// depends on etxlq_pkg
module etxlq_window (
   input  logic                   clock,
   input  logic                   reset,
   input  etxlq_pkg::win_req_type win_req,
   output etxlq_pkg::win_rsp_type win_rsp
);

   logic [etxlq_pkg::CNT_W-1:0] recv_mem [etxlq_pkg::WINDOW_SLOTS];
   logic [etxlq_pkg::CNT_W-1:0] lost_mem [etxlq_pkg::WINDOW_SLOTS];

   logic [etxlq_pkg::WINDOW_SLOTS-1:0] recv_vld_ff, recv_vld_in;
   logic [etxlq_pkg::WINDOW_SLOTS-1:0] lost_vld_ff, lost_vld_in;

   logic [etxlq_pkg::CNT_W-1:0] recv_rd_ff;
   logic [etxlq_pkg::CNT_W-1:0] lost_rd_ff;
   logic                        recv_rd_vld_ff;
   logic                        lost_rd_vld_ff;

   // invalid entries read as their reset value
   always_comb begin
      recv_vld_in = recv_vld_ff;
      lost_vld_in = lost_vld_ff;
      if (win_req.clr_lost) begin
         lost_vld_in = '0;
      end
      if (win_req.wr_en) begin
         recv_vld_in[win_req.addr] = 1'b1;
         lost_vld_in[win_req.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recv_vld_ff <= '0;
         lost_vld_ff <= '0;
      end else begin
         recv_vld_ff <= recv_vld_in;
         lost_vld_ff <= lost_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (win_req.wr_en) begin
         recv_mem[win_req.addr] <= win_req.wr_recv;
         lost_mem[win_req.addr] <= win_req.wr_lost;
      end
      if (win_req.rd_en) begin
         recv_rd_ff     <= recv_mem[win_req.addr];
         lost_rd_ff     <= lost_mem[win_req.addr];
         recv_rd_vld_ff <= recv_vld_ff[win_req.addr];
         lost_rd_vld_ff <= lost_vld_ff[win_req.addr];
      end
   end

   assign win_rsp.recv = recv_rd_vld_ff ? recv_rd_ff : '0;
   assign win_rsp.lost = lost_rd_vld_ff ? lost_rd_ff : etxlq_pkg::LOST_INIT;

endmodule
